>>> src/seg_lcd_pkg.sv
// ----------------------------------------------------------------------------
// Segment LCD driver package
// Shared types, command and event codes, font and segment map tables.
// ----------------------------------------------------------------------------
package seg_lcd_pkg;

  localparam int unsigned BufBytes = 12;
  localparam int unsigned BufIdxW  = $clog2(BufBytes);

  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_DIGIT = 2'd1;
  localparam logic [1:0] CMD_DOT   = 2'd2;

  localparam logic [1:0] EV_NONE = 2'd0;
  localparam logic [1:0] EV_REST = 2'd1;
  localparam logic [1:0] EV_SET  = 2'd2;

  localparam logic REG_SLOTS_PER_FRAME = 1'b0;
  localparam logic REG_SET_SLOT        = 1'b1;

  localparam logic [7:0] SLOTS_RESET    = 8'd10;
  localparam logic [7:0] SET_SLOT_RESET = 8'd3;

  typedef struct packed {
    logic [7:0] lv_a;
    logic [7:0] lv_c;
    logic [7:0] lv_l;
    logic       lv_d;
    logic [7:0] en_a;
    logic [7:0] en_c;
    logic [7:0] en_l;
    logic       en_d;
  } pins_t;

  localparam logic [6:0] GLYPH_MAP [4][3][5] = '{
    '{'{7'd2, 7'd3, 7'd4, 7'd5, 7'd6},
      '{7'd1, 7'd25, 7'd49, 7'd73, 7'd22},
      '{7'd0, 7'd24, 7'd48, 7'd72, 7'd94}},
    '{'{7'd74, 7'd75, 7'd76, 7'd77, 7'd78},
      '{7'd50, 7'd51, 7'd52, 7'd53, 7'd54},
      '{7'd26, 7'd27, 7'd28, 7'd29, 7'd30}},
    '{'{7'd8, 7'd9, 7'd10, 7'd11, 7'd12},
      '{7'd20, 7'd87, 7'd63, 7'd15, 7'd39},
      '{7'd92, 7'd91, 7'd67, 7'd19, 7'd43}},
    '{'{7'd80, 7'd81, 7'd82, 7'd83, 7'd84},
      '{7'd56, 7'd57, 7'd58, 7'd59, 7'd60},
      '{7'd32, 7'd33, 7'd34, 7'd35, 7'd36}}
  };

  localparam logic [6:0] DOT_MAP [2] = '{7'd46, 7'd70};

  // Glyph columns: bit 7 is the top row, bit 3 the bottom row.
  localparam logic [7:0] GLYPH_FONT [10][3] = '{
    '{8'hF8, 8'h88, 8'hF8}, '{8'h08, 8'hF8, 8'h48}, '{8'hE8, 8'hA8, 8'hB8},
    '{8'hF8, 8'hA8, 8'h88}, '{8'hF8, 8'h20, 8'hE0}, '{8'hB8, 8'hA8, 8'hE8},
    '{8'hB8, 8'hA8, 8'hF8}, '{8'hF8, 8'h80, 8'h80}, '{8'hF8, 8'hA8, 8'hF8},
    '{8'hF8, 8'hA8, 8'hE8}
  };

endpackage

>>> src/seg_lcd_if.sv
// ----------------------------------------------------------------------------
// Segment LCD driver channels
// Valid/ready interfaces for the command channel and the pin state channel.
// ----------------------------------------------------------------------------
interface seg_lcd_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [1:0] digit_pos;
  logic [3:0] digit_value;
  logic       dot_index;
  logic       dot_on;

  modport source (output valid, cmd, digit_pos, digit_value, dot_index, dot_on,
                  input ready);
  modport sink (input valid, cmd, digit_pos, digit_value, dot_index, dot_on,
                output ready);
endinterface

interface seg_lcd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] seg_a;
  logic [7:0] seg_c;
  logic [7:0] seg_l;
  logic       bp_d;
  logic [7:0] dir_a;
  logic [7:0] dir_c;
  logic [7:0] dir_l;
  logic       dir_bp_d;
  logic [1:0] drive_event;

  modport source (output valid, seg_a, seg_c, seg_l, bp_d, dir_a, dir_c, dir_l,
                  dir_bp_d, drive_event, input ready);
  modport sink (input valid, seg_a, seg_c, seg_l, bp_d, dir_a, dir_c, dir_l,
                dir_bp_d, drive_event, output ready);
endinterface

>>> src/segment_lcd_mux_driver.sv
// An accepted command transaction's pin state transaction is presented in the next cycle.
// Throughput: one transaction per cycle; the input is ready whenever the output
// register is empty or being drained in the same cycle.
// Reset (synchronous, rst_n low): frame buffer blank, phase and slot counter zero,
// all pins released, registers at 10 slots per frame and set slot 3.
// ----------------------------------------------------------------------------
// Multiplexed segment LCD driver
// Four-backplane LCD drive with a 12-byte frame buffer and digit rendering.
// ----------------------------------------------------------------------------
module segment_lcd_mux_driver
  import seg_lcd_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  seg_lcd_in_if.sink    in_ch,
  seg_lcd_out_if.source out_ch,
  input  logic          cfg_we,
  input  logic          cfg_index,
  input  logic [7:0]    cfg_wdata
);

  logic [7:0] slots_r, set_slot_r;
  logic [7:0] fb_r [BufBytes];
  logic [7:0] fb_nxt [BufBytes];
  logic [2:0] half_phase_r, half_phase_nxt;
  logic [7:0] slot_count_r, slot_count_nxt;
  pins_t      pins_r, pins_nxt, set_pins;
  logic       out_valid_r, out_valid_nxt;
  logic [1:0] event_r, event_nxt;
  logic       in_fire;

  logic [1:0]         phase_p;
  logic               phase_odd;
  logic [BufIdxW-1:0] base_idx;
  logic [7:0]         level_l, bp_mask;
  logic [7:0]         slot_inc;
  logic [6:0]         bit_addr;

  assign in_ch.ready   = !out_valid_r || out_ch.ready;
  assign in_fire       = in_ch.valid && in_ch.ready;
  assign out_valid_nxt = in_fire || (out_valid_r && !out_ch.ready);

  assign phase_p   = half_phase_r[2:1];
  assign phase_odd = half_phase_r[0];
  assign base_idx  = {1'b0, phase_p, 1'b0} + {2'b00, phase_p};
  assign bp_mask   = 8'(1) << phase_p;
  assign slot_inc  = slot_count_r + 8'd1;

  always_comb begin
    level_l = (fb_r[base_idx + BufIdxW'(2)] ^ {8{phase_odd}}) & 8'hF8;
    set_pins = '0;
    set_pins.lv_a = fb_r[base_idx] ^ {8{phase_odd}};
    set_pins.lv_c = fb_r[base_idx + BufIdxW'(1)] ^ {8{phase_odd}};
    if (phase_p == 2'd3) begin
      set_pins.en_d = 1'b1;
      set_pins.lv_d = phase_odd;
      set_pins.lv_l = level_l;
    end else begin
      set_pins.en_l = bp_mask;
      set_pins.lv_l = level_l | (phase_odd ? bp_mask : 8'h00);
    end
  end

  always_comb begin
    fb_nxt         = fb_r;
    half_phase_nxt = half_phase_r;
    slot_count_nxt = slot_count_r;
    pins_nxt       = pins_r;
    event_nxt      = EV_NONE;
    bit_addr       = '0;
    case (in_ch.cmd)
      CMD_TICK: begin
        if (slot_count_r == 8'd0) begin
          pins_nxt = '{lv_a: 8'h00, lv_c: 8'h00, lv_l: 8'h00, lv_d: 1'b0,
                       en_a: 8'hFF, en_c: 8'hFF, en_l: 8'hFF, en_d: 1'b1};
          event_nxt = EV_REST;
        end else if (slot_count_r == set_slot_r) begin
          pins_nxt       = set_pins;
          event_nxt      = EV_SET;
          half_phase_nxt = half_phase_r + 3'd1;
        end
        slot_count_nxt = (slot_inc >= slots_r) ? 8'd0 : slot_inc;
      end
      CMD_DIGIT: begin
        if (in_ch.digit_value <= 4'd9) begin
          for (int c = 0; c < 3; c++) begin
            for (int r = 0; r < 5; r++) begin
              bit_addr = GLYPH_MAP[in_ch.digit_pos][c][r];
              fb_nxt[bit_addr[6:3]][bit_addr[2:0]] =
                GLYPH_FONT[in_ch.digit_value][c][7-r];
            end
          end
        end
      end
      CMD_DOT: begin
        bit_addr = DOT_MAP[in_ch.dot_index];
        fb_nxt[bit_addr[6:3]][bit_addr[2:0]] = in_ch.dot_on;
      end
      default: begin
        event_nxt = EV_NONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slots_r      <= SLOTS_RESET;
      set_slot_r   <= SET_SLOT_RESET;
      half_phase_r <= '0;
      slot_count_r <= '0;
      pins_r       <= '0;
      out_valid_r  <= 1'b0;
      for (int i = 0; i < BufBytes; i++) begin
        fb_r[i] <= '0;
      end
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_SLOTS_PER_FRAME: slots_r    <= cfg_wdata;
          REG_SET_SLOT:        set_slot_r <= cfg_wdata;
          default:             slots_r    <= slots_r;
        endcase
      end
      if (in_fire) begin
        half_phase_r <= half_phase_nxt;
        slot_count_r <= slot_count_nxt;
        pins_r       <= pins_nxt;
        fb_r         <= fb_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      event_r <= event_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.seg_a       = pins_r.lv_a;
  assign out_ch.seg_c       = pins_r.lv_c;
  assign out_ch.seg_l       = pins_r.lv_l;
  assign out_ch.bp_d        = pins_r.lv_d;
  assign out_ch.dir_a       = pins_r.en_a;
  assign out_ch.dir_c       = pins_r.en_c;
  assign out_ch.dir_l       = pins_r.en_l;
  assign out_ch.dir_bp_d    = pins_r.en_d;
  assign out_ch.drive_event = event_r;

`ifndef SYNTHESIS
  a_rest_levels: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && event_r == EV_REST |->
      pins_r.en_a == 8'hFF && pins_r.lv_a == 8'h00 && pins_r.lv_l == 8'h00)
    else $error("rest transaction without all pins driven low");

  a_set_one_backplane: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && event_r == EV_SET |->
      pins_r.en_a == 8'h00 && pins_r.en_c == 8'h00 && pins_r.en_l[7:3] == 5'd0 &&
      $countones({pins_r.en_l[2:0], pins_r.en_d}) == 1)
    else $error("phase set does not enable exactly one backplane");

  a_write_keeps_timing: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_ch.cmd != CMD_TICK |=>
      $stable(half_phase_r) && $stable(slot_count_r) && $stable(pins_r))
    else $error("buffer write changed phase, slot or pin state");
`endif

endmodule
